>>> hw/rtl/dsms_pkg.sv
// ----------------------------------------------------------------------------
// Motion sequencer package
// Shared widths, codes and the controller/datapath command and status types.
// ----------------------------------------------------------------------------
package dsms_pkg;

    localparam int QueueDepthDefault = 8;
    localparam int StepBitsDefault   = 24;

    localparam int FactorW  = 22;
    localparam int PeriodW  = 16;
    localparam int AmountW  = 16;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 22;

    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_DRIVE   = 3'd1;
    localparam logic [2:0] CMD_TURN    = 3'd2;
    localparam logic [2:0] CMD_HOME    = 3'd3;
    localparam logic [2:0] CMD_PAUSE   = 3'd4;
    localparam logic [2:0] CMD_RESUME  = 3'd5;
    localparam logic [2:0] CMD_DISABLE = 3'd6;
    localparam logic [2:0] CMD_ENABLE  = 3'd7;

    localparam logic [2:0] REG_MM_FACTOR  = 3'd0;
    localparam logic [2:0] REG_DEG_FACTOR = 3'd1;
    localparam logic [2:0] REG_FAST       = 3'd2;
    localparam logic [2:0] REG_SLOW       = 3'd3;
    localparam logic [2:0] REG_RAMP       = 3'd4;
    localparam logic [2:0] REG_HOME_MIN   = 3'd5;
    localparam logic [2:0] REG_FLIP_R     = 3'd6;
    localparam logic [2:0] REG_FLIP_L     = 3'd7;

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_MOVING = 2'd1;
    localparam logic [1:0] MODE_PAUSED = 2'd2;
    localparam logic [1:0] MODE_HOMING = 2'd3;

    localparam logic [1:0] KIND_DRIVE = 2'd0;
    localparam logic [1:0] KIND_TURN  = 2'd1;
    localparam logic [1:0] KIND_HOME  = 2'd2;

    localparam logic [1:0] STATUS_NONE = 2'd0;
    localparam logic [1:0] STATUS_OK   = 2'd1;
    localparam logic [1:0] STATUS_INTR = 2'd2;

    typedef struct packed {
        logic load_cmd;
        logic mul_start;
        logic div_start;
        logic tick_eval;
    } dsms_ctl_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic need_div;
        logic need_mul;
    } dsms_stat_t;

endpackage

>>> hw/rtl/dsms_if.sv
// ----------------------------------------------------------------------------
// Sequencer channel interfaces
// Request, result and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface dsms_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [15:0] amount;
    logic        endstop_low;
    modport source (output valid, command, amount, endstop_low, input ready);
    modport sink   (input valid, command, amount, endstop_low, output ready);
endinterface

interface dsms_rsp_if;
    logic        valid;
    logic        ready;
    logic        step_pulse;
    logic [15:0] half_period;
    logic        dir_right;
    logic        dir_left;
    logic [1:0]  status;
    logic [1:0]  mode;
    logic        motors_enabled;
    logic        dropped;
    modport source (output valid, step_pulse, half_period, dir_right, dir_left, status,
                    mode, motors_enabled, dropped, input ready);
    modport sink   (input valid, step_pulse, half_period, dir_right, dir_left, status,
                    mode, motors_enabled, dropped, output ready);
endinterface

interface dsms_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [21:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/dsms_ctrl.sv
// ----------------------------------------------------------------------------
// Sequencer controller
// Sequences request capture, optional multiply or divide, and result hand-off.
// ----------------------------------------------------------------------------
module dsms_ctrl
    import dsms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    input  dsms_stat_t stat,
    output dsms_ctl_t  ctl
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_DECIDE, ST_MUL, ST_DIV, ST_EVAL, ST_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (stat.need_mul)
                begin
                    ctl.mul_start = 1'b1;
                    state_next = ST_MUL;
                end
                else if (stat.need_div)
                begin
                    ctl.div_start = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_MUL:
            begin
                if (stat.mul_done)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                ctl.tick_eval = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        ctl.load_cmd = (state_reg == ST_IDLE) && req_valid;
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = (state_reg == ST_OUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/dsms_datapath.sv
// ----------------------------------------------------------------------------
// Sequencer datapath
// Command queue, step scaling multiplier, serial ramp divider and motion state.
// ----------------------------------------------------------------------------
module dsms_datapath
    import dsms_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDefault,
    parameter int STEP_BITS   = StepBitsDefault
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  dsms_ctl_t           ctl,
    output dsms_stat_t          stat,
    input  logic [2:0]          command,
    input  logic [AmountW-1:0]  amount,
    input  logic                endstop_low,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    output logic                step_pulse,
    output logic [PeriodW-1:0]  half_period,
    output logic                dir_right,
    output logic                dir_left,
    output logic [1:0]          status,
    output logic [1:0]          mode,
    output logic                motors_enabled,
    output logic                dropped
);

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int ProdW = AmountW + FactorW;
    localparam int RW = 17;
    localparam logic [STEP_BITS-1:0] StepMax = '1;

    logic [FactorW-1:0] mm_factor_reg, deg_factor_reg;
    logic [PeriodW-1:0] fast_reg, slow_reg, ramp_reg, home_min_reg;
    logic               flip_r_reg, flip_l_reg;

    logic [2:0]         cmd_reg;
    logic [AmountW-1:0] amt_reg;
    logic               endstop_reg;

    logic [1:0]           mode_reg;
    logic [STEP_BITS-1:0] steps_left_reg, ramp_total_reg;
    logic [PeriodW-1:0]   home_count_reg;
    logic                 held_r_reg, held_l_reg, line_r_reg, line_l_reg;
    logic                 pause_reg, resume_reg, enable_reg;
    logic [17:0]          queue_mem [QUEUE_DEPTH];
    logic [QW-1:0]        head_reg;
    logic [CW-1:0]        count_reg;

    logic [ProdW-1:0]   prod_reg;
    logic [FactorW-1:0] mcand_reg;
    logic [AmountW-1:0] mplier_reg;
    logic [4:0]         mul_cnt_reg;
    logic               mul_busy_reg;

    logic [PeriodW+RW-1:0] dividend_reg;
    logic [PeriodW+RW:0]   rem_reg;
    logic [5:0]            div_cnt_reg;
    logic                  div_busy_reg;

    logic               out_pulse_reg;
    logic [PeriodW-1:0] out_half_reg;
    logic [1:0]         out_status_reg;
    logic               out_dropped_reg;

    logic [17:0]          head_entry;
    logic [1:0]           head_kind;
    logic                 head_neg;
    logic [AmountW-1:0]   head_mag;
    logic                 is_tick;
    logic [STEP_BITS-1:0] done_steps, r_min;
    logic [RW-1:0]        r_val;
    logic                 slow_ge;
    logic [PeriodW-1:0]   diff_mag;
    logic [PeriodW-1:0]   quot;
    logic [ProdW-1:0]     rounded;
    logic [STEP_BITS-1:0] steps_sat;
    logic [QW-1:0]        tail_idx;
    logic                 enq;

    assign head_entry = queue_mem[head_reg];
    assign head_kind  = head_entry[17:16];
    assign head_neg   = head_entry[15];
    assign head_mag   = head_neg ? (AmountW'(0) - head_entry[15:0]) : head_entry[15:0];
    assign is_tick    = (cmd_reg == CMD_TICK);

    assign done_steps = (ramp_total_reg >= steps_left_reg) ? ramp_total_reg - steps_left_reg
                                                           : '0;
    always_comb
    begin
        r_min = (steps_left_reg < done_steps) ? steps_left_reg : done_steps;
        if (r_min > STEP_BITS'(ramp_reg))
        begin
            r_min = STEP_BITS'(ramp_reg);
        end
    end
    assign r_val    = RW'(r_min);
    assign slow_ge  = (slow_reg >= fast_reg);
    assign diff_mag = slow_ge ? slow_reg - fast_reg : fast_reg - slow_reg;
    assign quot     = dividend_reg[PeriodW-1:0];

    assign rounded   = prod_reg + ProdW'(32'h8000);
    assign steps_sat = ((rounded >> 16) > ProdW'(StepMax)) ? StepMax
                                                           : STEP_BITS'(rounded >> 16);

    assign stat.need_mul = is_tick && (mode_reg == MODE_IDLE) && (count_reg != '0)
                           && (head_kind != KIND_HOME);
    assign stat.need_div = is_tick && (mode_reg == MODE_MOVING) && !pause_reg
                           && (steps_left_reg != '0) && (ramp_reg != '0);
    assign stat.mul_done = !mul_busy_reg;
    assign stat.div_done = !div_busy_reg;

    if (QUEUE_DEPTH > 1)
    begin : g_tail
        logic [QW:0] tail_sum;
        assign tail_sum = {1'b0, head_reg} + QW'(count_reg);
        assign tail_idx = (tail_sum >= (QW+1)'(QUEUE_DEPTH))
                          ? QW'(tail_sum - (QW+1)'(QUEUE_DEPTH)) : tail_sum[QW-1:0];
    end
    else
    begin : g_tail1
        assign tail_idx = '0;
    end

    assign enq = ctl.tick_eval && (cmd_reg == CMD_DRIVE || cmd_reg == CMD_TURN
                                   || cmd_reg == CMD_HOME)
                 && (count_reg < CW'(QUEUE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            queue_mem[tail_idx] <= {(cmd_reg == CMD_DRIVE) ? KIND_DRIVE :
                                    (cmd_reg == CMD_TURN) ? KIND_TURN : KIND_HOME,
                                    (cmd_reg == CMD_HOME) ? 16'd0 : amt_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_cmd)
        begin
            cmd_reg     <= command;
            amt_reg     <= amount;
            endstop_reg <= endstop_low;
        end
        if (ctl.mul_start)
        begin
            prod_reg   <= '0;
            mcand_reg  <= (head_kind == KIND_DRIVE) ? mm_factor_reg : deg_factor_reg;
            mplier_reg <= head_mag;
        end
        else if (mul_busy_reg)
        begin
            if (mplier_reg[0])
            begin
                prod_reg <= prod_reg + (ProdW'(mcand_reg) << mul_cnt_reg);
            end
            mplier_reg <= mplier_reg >> 1;
        end
        if (ctl.div_start)
        begin
            dividend_reg <= (PeriodW+RW)'(diff_mag) * (PeriodW+RW)'(r_val);
            rem_reg      <= '0;
        end
        else if (div_busy_reg)
        begin
            if ({rem_reg[PeriodW+RW-1:0], dividend_reg[PeriodW+RW-1]} >= (PeriodW+RW+1)'(ramp_reg))
            begin
                rem_reg <= {rem_reg[PeriodW+RW-1:0], dividend_reg[PeriodW+RW-1]}
                           - (PeriodW+RW+1)'(ramp_reg);
                dividend_reg <= {dividend_reg[PeriodW+RW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[PeriodW+RW-1:0], dividend_reg[PeriodW+RW-1]};
                dividend_reg <= {dividend_reg[PeriodW+RW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_busy_reg <= 1'b0;
            mul_cnt_reg  <= '0;
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            if (ctl.mul_start)
            begin
                mul_busy_reg <= 1'b1;
                mul_cnt_reg  <= '0;
            end
            else if (mul_busy_reg)
            begin
                mul_cnt_reg <= mul_cnt_reg + 5'd1;
                if (mul_cnt_reg == 5'(AmountW - 1))
                begin
                    mul_busy_reg <= 1'b0;
                end
            end
            if (ctl.div_start)
            begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= '0;
            end
            else if (div_busy_reg)
            begin
                div_cnt_reg <= div_cnt_reg + 6'd1;
                if (div_cnt_reg == 6'(PeriodW + RW - 1))
                begin
                    div_busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mm_factor_reg  <= FactorW'(695359);
            deg_factor_reg <= FactorW'(1371401);
            fast_reg       <= PeriodW'(200);
            slow_reg       <= PeriodW'(800);
            ramp_reg       <= PeriodW'(300);
            home_min_reg   <= PeriodW'(100);
            flip_r_reg     <= 1'b0;
            flip_l_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MM_FACTOR:  mm_factor_reg  <= cfg_data;
                REG_DEG_FACTOR: deg_factor_reg <= cfg_data;
                REG_FAST:       fast_reg       <= cfg_data[PeriodW-1:0];
                REG_SLOW:       slow_reg       <= cfg_data[PeriodW-1:0];
                REG_RAMP:       ramp_reg       <= cfg_data[PeriodW-1:0];
                REG_HOME_MIN:   home_min_reg   <= cfg_data[PeriodW-1:0];
                REG_FLIP_R:     flip_r_reg     <= cfg_data[0];
                REG_FLIP_L:     flip_l_reg     <= cfg_data[0];
                default:        flip_l_reg     <= flip_l_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_IDLE;
            steps_left_reg  <= '0;
            ramp_total_reg  <= '0;
            home_count_reg  <= '0;
            held_r_reg      <= 1'b0;
            held_l_reg      <= 1'b0;
            line_r_reg      <= 1'b0;
            line_l_reg      <= 1'b0;
            pause_reg       <= 1'b0;
            resume_reg      <= 1'b0;
            enable_reg      <= 1'b0;
            head_reg        <= '0;
            count_reg       <= '0;
            out_pulse_reg   <= 1'b0;
            out_half_reg    <= '0;
            out_status_reg  <= STATUS_NONE;
            out_dropped_reg <= 1'b0;
        end
        else if (ctl.tick_eval)
        begin
            out_pulse_reg   <= 1'b0;
            out_half_reg    <= '0;
            out_status_reg  <= STATUS_NONE;
            out_dropped_reg <= 1'b0;
            case (cmd_reg)
                CMD_DRIVE, CMD_TURN, CMD_HOME:
                begin
                    pause_reg <= 1'b0;
                    if (enq)
                    begin
                        count_reg <= count_reg + CW'(1);
                    end
                    else
                    begin
                        out_dropped_reg <= 1'b1;
                    end
                end
                CMD_PAUSE:
                begin
                    pause_reg <= 1'b1;
                end
                CMD_RESUME:
                begin
                    resume_reg <= 1'b1;
                end
                CMD_DISABLE:
                begin
                    pause_reg      <= 1'b1;
                    enable_reg     <= 1'b0;
                    out_status_reg <= STATUS_OK;
                end
                CMD_ENABLE:
                begin
                    enable_reg     <= 1'b1;
                    out_status_reg <= STATUS_OK;
                end
                default:
                begin
                    case (mode_reg)
                        MODE_IDLE:
                        begin
                            if (count_reg != '0)
                            begin
                                head_reg  <= (head_reg == QW'(QUEUE_DEPTH - 1)) ? '0
                                             : head_reg + QW'(1);
                                count_reg <= count_reg - CW'(1);
                                if (head_kind == KIND_HOME)
                                begin
                                    line_r_reg     <= ~flip_r_reg;
                                    line_l_reg     <= flip_l_reg;
                                    home_count_reg <= '0;
                                    mode_reg       <= MODE_HOMING;
                                end
                                else
                                begin
                                    logic pos;
                                    logic hr, hl;
                                    pos = !head_neg || (steps_sat == '0);
                                    hr  = (head_kind == KIND_DRIVE) ? !pos : pos;
                                    hl  = pos;
                                    held_r_reg     <= hr ^ flip_r_reg;
                                    held_l_reg     <= hl ^ flip_l_reg;
                                    line_r_reg     <= hr ^ flip_r_reg;
                                    line_l_reg     <= hl ^ flip_l_reg;
                                    steps_left_reg <= steps_sat;
                                    ramp_total_reg <= steps_sat;
                                    mode_reg       <= MODE_MOVING;
                                end
                            end
                        end
                        MODE_MOVING:
                        begin
                            if (pause_reg)
                            begin
                                pause_reg <= 1'b0;
                                mode_reg  <= MODE_PAUSED;
                            end
                            else if (steps_left_reg == '0)
                            begin
                                mode_reg       <= MODE_IDLE;
                                out_status_reg <= STATUS_OK;
                            end
                            else
                            begin
                                out_pulse_reg  <= 1'b1;
                                steps_left_reg <= steps_left_reg - STEP_BITS'(1);
                                if (ramp_reg == '0)
                                begin
                                    out_half_reg <= slow_reg;
                                end
                                else if (slow_ge)
                                begin
                                    out_half_reg <= slow_reg - quot;
                                end
                                else
                                begin
                                    out_half_reg <= slow_reg + quot;
                                end
                            end
                        end
                        MODE_PAUSED:
                        begin
                            if (resume_reg)
                            begin
                                resume_reg     <= 1'b0;
                                ramp_total_reg <= steps_left_reg;
                                line_r_reg     <= held_r_reg;
                                line_l_reg     <= held_l_reg;
                                mode_reg       <= MODE_MOVING;
                            end
                            else if (pause_reg)
                            begin
                                pause_reg      <= 1'b0;
                                steps_left_reg <= '0;
                                mode_reg       <= MODE_IDLE;
                                out_status_reg <= STATUS_INTR;
                            end
                        end
                        default:
                        begin
                            if (pause_reg)
                            begin
                                pause_reg      <= 1'b0;
                                mode_reg       <= MODE_IDLE;
                                out_status_reg <= STATUS_INTR;
                            end
                            else if ((home_count_reg >= home_min_reg) && endstop_reg)
                            begin
                                mode_reg       <= MODE_IDLE;
                                out_status_reg <= STATUS_OK;
                            end
                            else
                            begin
                                out_pulse_reg <= 1'b1;
                                out_half_reg  <= slow_reg;
                                if (home_count_reg != '1)
                                begin
                                    home_count_reg <= home_count_reg + PeriodW'(1);
                                end
                            end
                        end
                    endcase
                end
            endcase
        end
    end

    assign step_pulse     = out_pulse_reg;
    assign half_period    = out_half_reg;
    assign dir_right      = line_r_reg;
    assign dir_left       = line_l_reg;
    assign status         = out_status_reg;
    assign mode           = mode_reg;
    assign motors_enabled = enable_reg;
    assign dropped        = out_dropped_reg;

endmodule

>>> hw/rtl/differential_stepper_motion_sequencer_core.sv
// ----------------------------------------------------------------------------
// Differential stepper motion sequencer
// Two-wheel stepper sequencer with a command queue and linear speed ramp.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel: a command code, a signed amount and the
// sampled endstop level. Each request yields exactly one result on the rsp
// channel with the step decision, half period, direction levels, status and
// mode. Registers are written through the cfg channel, which is always ready.
// A request is processed one at a time. Most requests go from capture through
// evaluation straight to the result. A tick that starts a drive or turn first
// runs the shift-add step scaling multiplier, and a moving tick that issues a
// ramped step first runs the restoring divider for the ramp. The next request
// is accepted in the cycle after the result is taken.
// Reset clears the queue, the motion state and the flags, and loads the
// register defaults. While the receiver holds rsp ready low, the result stays
// valid and stable and no new request is accepted.
// ----------------------------------------------------------------------------
module differential_stepper_motion_sequencer_core
    import dsms_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDefault,
    parameter int STEP_BITS   = StepBitsDefault
)
(
    input logic       clk,
    input logic       rst_n,
    dsms_req_if.sink  req,
    dsms_rsp_if.source rsp,
    dsms_cfg_if.sink  cfg
);

    dsms_ctl_t  ctl;
    dsms_stat_t stat;

    assign cfg.ready = 1'b1;

    dsms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    dsms_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .STEP_BITS   (STEP_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .stat           (stat),
        .command        (req.command),
        .amount         (req.amount),
        .endstop_low    (req.endstop_low),
        .cfg_we         (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .step_pulse     (rsp.step_pulse),
        .half_period    (rsp.half_period),
        .dir_right      (rsp.dir_right),
        .dir_left       (rsp.dir_left),
        .status         (rsp.status),
        .mode           (rsp.mode),
        .motors_enabled (rsp.motors_enabled),
        .dropped        (rsp.dropped)
    );

endmodule

>>> hw/rtl/dsms_checker.sv
// ----------------------------------------------------------------------------
// Sequencer port checker
// Port-level properties of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module dsms_checker
    import dsms_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        step_pulse,
    input logic [15:0] half_period,
    input logic [1:0]  status
);

    // A result that is not taken keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(half_period) && $stable(status))
        else $error("stalled result changed");

    // No new request is taken while a result is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("request accepted with result pending");

    // A result without a step carries no half period.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !step_pulse |-> half_period == 16'd0)
        else $error("half period without step");

    // A step never coincides with a finishing status.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && step_pulse |-> status == STATUS_NONE)
        else $error("step with status");

endmodule

bind differential_stepper_motion_sequencer_core dsms_checker u_dsms_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .step_pulse  (rsp.step_pulse),
    .half_period (rsp.half_period),
    .status      (rsp.status)
);

>>> tb/differential_stepper_motion_sequencer_core_test.sv
// ----------------------------------------------------------------------------
// Motion sequencer testbench
// Drives requests, register writes and result back-pressure at random and
// checks every result against a cycle-free prediction of the sequencer.
// ----------------------------------------------------------------------------
module differential_stepper_motion_sequencer_core_test;
    import dsms_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        step_pulse;
        logic [15:0] half_period;
        logic        dir_right;
        logic        dir_left;
        logic [1:0]  status;
        logic [1:0]  mode;
        logic        motors_enabled;
        logic        dropped;
    } step_result_t;

    class motion_scoreboard;
        logic [21:0] mm_factor, deg_factor;
        logic [15:0] fast_hp, slow_hp, ramp_len, home_min;
        logic        flip_r, flip_l;
        logic [1:0]  mode;
        logic [23:0] steps_left, ramp_total;
        logic [15:0] home_count;
        logic        held_r, held_l, line_r, line_l;
        logic        pause_req, resume_req, enabled;
        logic [17:0] queue [8];
        int          q_count, q_head;
        step_result_t expected [$];
        int          mismatches, results_seen, steps_seen;

        function void reset_state();
            mm_factor = 22'd695359; deg_factor = 22'd1371401;
            fast_hp = 16'd200; slow_hp = 16'd800; ramp_len = 16'd300;
            home_min = 16'd100; flip_r = 0; flip_l = 0;
            mode = MODE_IDLE; steps_left = 0; ramp_total = 0; home_count = 0;
            held_r = 0; held_l = 0; line_r = 0; line_l = 0;
            pause_req = 0; resume_req = 0; enabled = 0;
            q_count = 0; q_head = 0;
            mismatches = 0; results_seen = 0; steps_seen = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [21:0] d);
            case (idx)
                REG_MM_FACTOR:  mm_factor = d;
                REG_DEG_FACTOR: deg_factor = d;
                REG_FAST:       fast_hp = d[15:0];
                REG_SLOW:       slow_hp = d[15:0];
                REG_RAMP:       ramp_len = d[15:0];
                REG_HOME_MIN:   home_min = d[15:0];
                REG_FLIP_R:     flip_r = d[0];
                default:        flip_l = d[0];
            endcase
        endfunction

        function logic [15:0] ramp_half(logic [23:0] done, logic [23:0] rem);
            longint r, diff, q;
            r = done;
            if (rem < r) r = rem;
            if (ramp_len < r) r = ramp_len;
            if (ramp_len == 0) return slow_hp;
            if (slow_hp >= fast_hp) begin
                diff = slow_hp - fast_hp;
                q = diff * r / ramp_len;
                return slow_hp - q[15:0];
            end
            diff = fast_hp - slow_hp;
            q = diff * r / ramp_len;
            return slow_hp + q[15:0];
        endfunction

        function void start_entry(logic [17:0] entry);
            logic [1:0]  kind;
            logic        neg, pos;
            longint      mag, steps;
            kind = entry[17:16];
            neg = entry[15];
            if (kind == KIND_HOME) begin
                line_r = 1 ^ flip_r; line_l = flip_l;
                home_count = 0; mode = MODE_HOMING;
                return;
            end
            mag = neg ? (65536 - entry[15:0]) : entry[15:0];
            steps = (mag * ((kind == KIND_DRIVE) ? mm_factor : deg_factor) + 32768) >>> 16;
            if (steps > 24'hFFFFFF) steps = 24'hFFFFFF;
            pos = !neg || steps == 0;
            if (kind == KIND_DRIVE) begin
                held_r = !pos ^ flip_r; held_l = pos ^ flip_l;
            end else begin
                held_r = pos ^ flip_r; held_l = pos ^ flip_l;
            end
            steps_left = steps[23:0]; ramp_total = steps[23:0];
            line_r = held_r; line_l = held_l; mode = MODE_MOVING;
        endfunction

        function void push_cmd(logic [1:0] kind, logic [15:0] amt, output logic drop);
            pause_req = 0;
            drop = 0;
            if (q_count >= 8) begin
                drop = 1;
                return;
            end
            queue[(q_head + q_count) % 8] = {kind, amt};
            q_count++;
        endfunction

        function void note_request(logic [2:0] cmd, logic [15:0] amt, logic endstop);
            step_result_t res;
            logic drop;
            res = '0;
            drop = 0;
            case (cmd)
                CMD_DRIVE:   push_cmd(KIND_DRIVE, amt, drop);
                CMD_TURN:    push_cmd(KIND_TURN, amt, drop);
                CMD_HOME:    push_cmd(KIND_HOME, 16'd0, drop);
                CMD_PAUSE:   pause_req = 1;
                CMD_RESUME:  resume_req = 1;
                CMD_DISABLE: begin pause_req = 1; enabled = 0; res.status = STATUS_OK; end
                CMD_ENABLE:  begin enabled = 1; res.status = STATUS_OK; end
                default: begin
                    if (mode == MODE_IDLE) begin
                        if (q_count > 0) begin
                            start_entry(queue[q_head]);
                            q_head = (q_head + 1) % 8;
                            q_count--;
                        end
                    end else if (mode == MODE_MOVING) begin
                        if (pause_req) begin
                            pause_req = 0; mode = MODE_PAUSED;
                        end else if (steps_left == 0) begin
                            mode = MODE_IDLE; res.status = STATUS_OK;
                        end else begin
                            res.half_period = ramp_half(
                                ramp_total >= steps_left ? ramp_total - steps_left : 24'd0,
                                steps_left);
                            res.step_pulse = 1;
                            steps_left--;
                        end
                    end else if (mode == MODE_PAUSED) begin
                        if (resume_req) begin
                            resume_req = 0; ramp_total = steps_left;
                            line_r = held_r; line_l = held_l; mode = MODE_MOVING;
                        end else if (pause_req) begin
                            pause_req = 0; steps_left = 0; mode = MODE_IDLE;
                            res.status = STATUS_INTR;
                        end
                    end else begin
                        if (pause_req) begin
                            pause_req = 0; mode = MODE_IDLE; res.status = STATUS_INTR;
                        end else if (home_count >= home_min && endstop) begin
                            mode = MODE_IDLE; res.status = STATUS_OK;
                        end else begin
                            res.step_pulse = 1; res.half_period = slow_hp;
                            if (home_count != 16'hFFFF) home_count++;
                        end
                    end
                end
            endcase
            res.dir_right = line_r; res.dir_left = line_l;
            res.mode = mode; res.motors_enabled = enabled; res.dropped = drop;
            expected.push_back(res);
        endfunction

        function void check_result(step_result_t got);
            step_result_t want;
            results_seen++;
            if (got.step_pulse) steps_seen++;
            if (expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %p", got);
                return;
            end
            want = expected.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch at %0t: expected %p, got %p", $realtime, want, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    dsms_req_if req ();
    dsms_rsp_if rsp ();
    dsms_cfg_if cfg ();
    motion_scoreboard sb;
    bit hold_rsp;
    bit long_stall_req;
    int reqs_sent;

    differential_stepper_motion_sequencer_core u_dut (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
    );

    initial begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial begin
        #3000000;
        $display("Timeout waiting for results");
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk) begin
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_result({rsp.step_pulse, rsp.half_period, rsp.dir_right, rsp.dir_left,
                             rsp.status, rsp.mode, rsp.motors_enabled, rsp.dropped});
        if (rst_n && req.valid && req.ready)
            sb.note_request(req.command, req.amount, req.endstop_low);
    end

    // Result side back-pressure, with a long hold-off when one is requested.
    initial begin
        int wait_cycles;
        rsp.ready = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (long_stall_req) begin
                rsp.ready <= 0;
                repeat (300) @(negedge clk);
                long_stall_req = 0;
            end
            if (hold_rsp) wait_cycles = 0;
            else wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (wait_cycles > 0) begin
                rsp.ready <= 0;
                repeat (wait_cycles - 1) @(negedge clk);
                @(negedge clk);
            end
            rsp.ready <= 1;
            @(posedge clk);
            while (!rsp.valid) @(posedge clk);
        end
    end

    // Valid stays high between back-to-back requests and drops only for a gap.
    task automatic send_request(logic [2:0] cmd, logic [15:0] amt, logic endstop, bit gaps);
        int gap;
        gap = gaps ? (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19)) : 0;
        if (gap > 0) begin
            req.valid <= 0;
            repeat (gap) @(negedge clk);
        end
        req.valid <= 1;
        req.command <= cmd;
        req.amount <= amt;
        req.endstop_low <= endstop;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        @(negedge clk);
        reqs_sent++;
    endtask

    task automatic wait_drained();
        req.valid <= 0;
        while (sb.expected.size() != 0) @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [21:0] d);
        @(negedge clk);
        cfg.valid <= 1;
        cfg.index <= idx;
        cfg.data <= d;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        sb.write_reg(idx, d);
        @(negedge clk);
        cfg.valid <= 0;
    endtask

    task automatic write_profile(int sel);
        logic [21:0] v [8];
        case (sel)
            0: v = '{22'd695359, 22'd1371401, 22'd200, 22'd800, 22'd300, 22'd100,
                     22'd0, 22'd0};
            1: v = '{22'd1, 22'h3FFFFF, 22'd1, 22'd65535, 22'd1, 22'd0, 22'd1, 22'd1};
            2: v = '{22'h3FFFFF, 22'd1, 22'd65535, 22'd1, 22'd65535, 22'd65535,
                     22'd0, 22'd1};
            3: v = '{22'd0, 22'd0, 22'd300, 22'd100, 22'd0, 22'd3, 22'd1, 22'd0};
            default: begin
                v[0] = 22'($urandom_range(1, 200000)); v[1] = 22'($urandom_range(1, 200000));
                v[2] = 22'($urandom_range(1, 1000)); v[3] = 22'($urandom_range(1, 1000));
                v[4] = 22'($urandom_range(0, 8)); v[5] = 22'($urandom_range(0, 12));
                v[6] = 22'($urandom_range(0, 1)); v[7] = 22'($urandom_range(0, 1));
            end
        endcase
        for (int i = 0; i < 8; i++) write_reg(i[2:0], v[i]);
    endtask

    // Mostly well-formed move sequences: queue, tick through, sometimes pause.
    task automatic random_burst();
        int n;
        logic [2:0] cmd;
        logic [15:0] amt;
        n = $urandom_range(5, 30);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 19))
                0, 1:  cmd = CMD_DRIVE;
                2:     cmd = CMD_TURN;
                3:     cmd = CMD_HOME;
                4:     cmd = CMD_PAUSE;
                5:     cmd = CMD_RESUME;
                6:     cmd = CMD_DISABLE;
                7:     cmd = CMD_ENABLE;
                default: cmd = CMD_TICK;
            endcase
            amt = ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                              : 16'($urandom_range(0, 6) - 3);
            send_request(cmd, amt, 1'($urandom_range(0, 1)), 1'b1);
        end
    endtask

    initial begin
        rst_n = 0;
        req.valid = 0; req.command = CMD_TICK; req.amount = 0; req.endstop_low = 0;
        cfg.valid = 0; cfg.index = REG_MM_FACTOR; cfg.data = 0;
        hold_rsp = 0; long_stall_req = 0; reqs_sent = 0;
        sb = new();
        sb.reset_state();
        repeat (10) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        write_profile(3);
        send_request(CMD_ENABLE, 0, 0, 0);
        send_request(CMD_DRIVE, 16'h7FFF, 0, 0);
        send_request(CMD_DRIVE, 16'h8000, 0, 0);
        send_request(CMD_TICK, 0, 0, 0);
        send_request(CMD_TICK, 0, 0, 0);
        send_request(CMD_TICK, 0, 0, 0);
        send_request(CMD_TICK, 0, 0, 0);
        wait_drained();
        write_profile(1);
        send_request(CMD_TURN, 16'hFFFF, 0, 0);
        send_request(CMD_TICK, 0, 0, 0);
        send_request(CMD_TICK, 0, 0, 0);
        send_request(CMD_PAUSE, 0, 0, 0);
        send_request(CMD_TICK, 0, 0, 0);
        send_request(CMD_RESUME, 0, 0, 0);
        send_request(CMD_TICK, 0, 0, 0);
        send_request(CMD_TICK, 0, 0, 0);
        send_request(CMD_PAUSE, 0, 0, 0);
        send_request(CMD_TICK, 0, 0, 0);
        send_request(CMD_PAUSE, 0, 0, 0);
        send_request(CMD_TICK, 0, 0, 0);
        send_request(CMD_HOME, 0, 0, 0);
        send_request(CMD_TICK, 0, 0, 0);
        send_request(CMD_TICK, 0, 1, 0);
        send_request(CMD_DISABLE, 0, 0, 0);
        send_request(CMD_TICK, 0, 0, 0);
        wait_drained();

        // Send more drives than the queue holds, with a long result-side hold-off.
        long_stall_req = 1;
        for (int i = 0; i < 12; i++) send_request(CMD_DRIVE, 16'($urandom), 0, 0);
        wait_drained();

        for (int phase = 0; phase < 12; phase++) begin
            write_profile((phase % 4 == 2) ? 2 : 4);
            while (reqs_sent < 60 + phase * 100) random_burst();
            wait_drained();
        end
        write_profile(0);
        for (int i = 0; i < 40; i++) send_request(CMD_TICK, 0, 1, 1);
        wait_drained();

        $display("Requests sent: %0d, results checked: %0d, step results: %0d",
                 reqs_sent, sb.results_seen, sb.steps_seen);
        if (sb.mismatches == 0 && sb.expected.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
